[sv/cpe_pkg.sv]
`timescale 1ns / 1ps
package cpe_pkg;

	localparam int WORD = 32;
	localparam int FRAC = 24;

	typedef logic signed [WORD-1:0] word_t;

	localparam word_t VMAX = {1'b0, {(WORD-1){1'b1}}};
	localparam word_t VMIN = {1'b1, {(WORD-1){1'b0}}};

	localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
	localparam logic [63:0] H64 = (HALF_PI_Q61 + (64'd1 << (60 - FRAC))) >> (61 - FRAC);
	localparam word_t H_VAL    = word_t'(H64);
	localparam word_t H2_VAL   = word_t'(H64 / 2);
	localparam word_t ONE_VAL  = word_t'(64'd1 << FRAC);
	localparam word_t FT_VAL   = word_t'(((64'd4 << FRAC) + 64'd1) / 3);
	localparam word_t ROUND_HALF = word_t'(64'd1 << (FRAC - 1));

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CART_MASS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE_MASS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_ANG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd5;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_MULK, OP_ABSH, OP_SUBR,
		OP_SEL, OP_CNEG, OP_MOV, OP_DIV, OP_DIVS, OP_DIVU
	} alu_op_t;

	typedef enum logic [1:0] {C_K0, C_K1, C_K01, C_TNEG} cond_t;

	typedef logic [5:0] opnd_t;

	// temporaries live in the scratch RAM, codes with the top bit set are fixed sources
	localparam opnd_t T0 = 6'd0, T1 = 6'd1, T2 = 6'd2, T3 = 6'd3, T4 = 6'd4, T5 = 6'd5;
	localparam opnd_t T6 = 6'd6, T7 = 6'd7, T8 = 6'd8, T9 = 6'd9, T10 = 6'd10;
	localparam opnd_t T11 = 6'd11, T12 = 6'd12, T13 = 6'd13, T14 = 6'd14, T15 = 6'd15;
	localparam opnd_t S_PA = 6'h20, S_VEL = 6'h21, S_ANG = 6'h22, S_RATE = 6'h23;
	localparam opnd_t S_G = 6'h24, S_MC = 6'h25, S_MP = 6'h26, S_L = 6'h27, S_DT = 6'h28;
	localparam opnd_t S_FORCE = 6'h29, S_ONE = 6'h2A, S_FT = 6'h2B, S_H2 = 6'h2C;
	localparam opnd_t S_H = 6'h2D;
	localparam opnd_t S_SD0 = 6'h30, S_SD1 = 6'h31, S_SD2 = 6'h32, S_SD3 = 6'h33;
	localparam opnd_t S_SD4 = 6'h34;
	localparam opnd_t S_CD0 = 6'h35, S_CD1 = 6'h36, S_CD2 = 6'h37, S_CD3 = 6'h38;
	localparam opnd_t S_CD4 = 6'h39;

	typedef struct packed {
		alu_op_t op;
		opnd_t   dst;
		opnd_t   src_a;
		opnd_t   src_b;
		cond_t   cond;
	} uop_t;

	typedef struct packed {
		logic take;
		logic restart;
		logic set_fail;
		logic issue;
		logic exec;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic mode;
		logic fail_hit;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	localparam int PC_W = 7;
	localparam logic [PC_W-1:0] PROG_LAST = 7'd73;

	function automatic logic is_div(alu_op_t op);
		return (op == OP_DIV) || (op == OP_DIVS) || (op == OP_DIVU);
	endfunction

	function automatic uop_t mk(alu_op_t op, opnd_t d, opnd_t a, opnd_t b, cond_t c);
		uop_t u;
		u.op = op;
		u.dst = d;
		u.src_a = a;
		u.src_b = b;
		u.cond = c;
		return u;
	endfunction

	// one step: sin/cos by range reduction and Taylor, then the cart-pole update
	function automatic uop_t prog(logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			7'd0:  u = mk(OP_ABSH, T0, S_ANG, S_H2, C_K0);
			7'd1:  u = mk(OP_DIVU, T1, T0, S_H, C_K0);
			7'd2:  u = mk(OP_MULK, T2, T1, S_H, C_K0);
			7'd3:  u = mk(OP_SUBR, T3, T0, T2, C_K0);
			7'd4:  u = mk(OP_SUBR, T3, T3, S_H2, C_K0);
			7'd5:  u = mk(OP_MUL, T4, T3, T3, C_K0);
			7'd6:  u = mk(OP_MUL, T7, T4, S_ONE, C_K0);
			7'd7:  u = mk(OP_DIVS, T7, T7, S_SD0, C_K0);
			7'd8:  u = mk(OP_SUB, T5, S_ONE, T7, C_K0);
			7'd9:  u = mk(OP_MUL, T7, T4, S_ONE, C_K0);
			7'd10: u = mk(OP_DIVS, T7, T7, S_CD0, C_K0);
			7'd11: u = mk(OP_SUB, T6, S_ONE, T7, C_K0);
			7'd12: u = mk(OP_MUL, T7, T4, T5, C_K0);
			7'd13: u = mk(OP_DIVS, T7, T7, S_SD1, C_K0);
			7'd14: u = mk(OP_SUB, T5, S_ONE, T7, C_K0);
			7'd15: u = mk(OP_MUL, T7, T4, T6, C_K0);
			7'd16: u = mk(OP_DIVS, T7, T7, S_CD1, C_K0);
			7'd17: u = mk(OP_SUB, T6, S_ONE, T7, C_K0);
			7'd18: u = mk(OP_MUL, T7, T4, T5, C_K0);
			7'd19: u = mk(OP_DIVS, T7, T7, S_SD2, C_K0);
			7'd20: u = mk(OP_SUB, T5, S_ONE, T7, C_K0);
			7'd21: u = mk(OP_MUL, T7, T4, T6, C_K0);
			7'd22: u = mk(OP_DIVS, T7, T7, S_CD2, C_K0);
			7'd23: u = mk(OP_SUB, T6, S_ONE, T7, C_K0);
			7'd24: u = mk(OP_MUL, T7, T4, T5, C_K0);
			7'd25: u = mk(OP_DIVS, T7, T7, S_SD3, C_K0);
			7'd26: u = mk(OP_SUB, T5, S_ONE, T7, C_K0);
			7'd27: u = mk(OP_MUL, T7, T4, T6, C_K0);
			7'd28: u = mk(OP_DIVS, T7, T7, S_CD3, C_K0);
			7'd29: u = mk(OP_SUB, T6, S_ONE, T7, C_K0);
			7'd30: u = mk(OP_MUL, T7, T4, T5, C_K0);
			7'd31: u = mk(OP_DIVS, T7, T7, S_SD4, C_K0);
			7'd32: u = mk(OP_SUB, T5, S_ONE, T7, C_K0);
			7'd33: u = mk(OP_MUL, T7, T4, T6, C_K0);
			7'd34: u = mk(OP_DIVS, T7, T7, S_CD4, C_K0);
			7'd35: u = mk(OP_SUB, T6, S_ONE, T7, C_K0);
			7'd36: u = mk(OP_MUL, T5, T3, T5, C_K0);
			7'd37: u = mk(OP_SEL, T7, T6, T5, C_K0);
			7'd38: u = mk(OP_CNEG, T7, T7, S_ONE, C_K1);
			7'd39: u = mk(OP_CNEG, T7, T7, S_ONE, C_TNEG);
			7'd40: u = mk(OP_SEL, T8, T5, T6, C_K0);
			7'd41: u = mk(OP_CNEG, T8, T8, S_ONE, C_K01);
			7'd42: u = mk(OP_ADD, T9, S_MC, S_MP, C_K0);
			7'd43: u = mk(OP_MUL, T10, S_MP, S_L, C_K0);
			7'd44: u = mk(OP_MUL, T11, S_RATE, S_RATE, C_K0);
			7'd45: u = mk(OP_MUL, T11, T11, T7, C_K0);
			7'd46: u = mk(OP_NEG, T12, S_FORCE, S_ONE, C_K0);
			7'd47: u = mk(OP_MUL, T13, T10, T11, C_K0);
			7'd48: u = mk(OP_SUB, T12, T12, T13, C_K0);
			7'd49: u = mk(OP_DIV, T12, T12, T9, C_K0);
			7'd50: u = mk(OP_MUL, T13, S_G, T7, C_K0);
			7'd51: u = mk(OP_MUL, T14, T8, T12, C_K0);
			7'd52: u = mk(OP_ADD, T13, T13, T14, C_K0);
			7'd53: u = mk(OP_MUL, T14, T8, T8, C_K0);
			7'd54: u = mk(OP_MUL, T14, S_MP, T14, C_K0);
			7'd55: u = mk(OP_DIV, T14, T14, T9, C_K0);
			7'd56: u = mk(OP_SUB, T14, S_FT, T14, C_K0);
			7'd57: u = mk(OP_MUL, T14, S_L, T14, C_K0);
			7'd58: u = mk(OP_DIV, T13, T13, T14, C_K0);
			7'd59: u = mk(OP_MUL, T14, T13, T8, C_K0);
			7'd60: u = mk(OP_SUB, T14, T11, T14, C_K0);
			7'd61: u = mk(OP_MUL, T14, T10, T14, C_K0);
			7'd62: u = mk(OP_ADD, T14, S_FORCE, T14, C_K0);
			7'd63: u = mk(OP_DIV, T14, T14, T9, C_K0);
			7'd64: u = mk(OP_MUL, T14, T14, S_DT, C_K0);
			7'd65: u = mk(OP_ADD, T14, S_VEL, T14, C_K0);
			7'd66: u = mk(OP_MUL, T12, T13, S_DT, C_K0);
			7'd67: u = mk(OP_ADD, T12, S_RATE, T12, C_K0);
			7'd68: u = mk(OP_MUL, T15, T14, S_DT, C_K0);
			7'd69: u = mk(OP_ADD, S_PA, S_PA, T15, C_K0);
			7'd70: u = mk(OP_MUL, T15, T12, S_DT, C_K0);
			7'd71: u = mk(OP_ADD, S_ANG, S_ANG, T15, C_K0);
			7'd72: u = mk(OP_MOV, S_VEL, T14, S_ONE, C_K0);
			7'd73: u = mk(OP_MOV, S_RATE, T12, S_ONE, C_K0);
			default: u = mk(OP_MOV, T15, T15, S_ONE, C_K0);
		endcase
		return u;
	endfunction

endpackage

[sv/cpe_ifs.sv]
`timescale 1ns / 1ps
interface cpe_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic signed [31:0] force_req;
	modport source(output valid, mode, force_req, input ready);
	modport sink(input valid, mode, force_req, output ready);
endinterface

interface cpe_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] new_position;
	logic signed [31:0] new_velocity;
	logic signed [31:0] new_angle;
	logic signed [31:0] new_rate;
	logic has_failed;
	modport source(output valid, new_position, new_velocity, new_angle, new_rate,
		has_failed, input ready);
	modport sink(input valid, new_position, new_velocity, new_angle, new_rate,
		has_failed, output ready);
endinterface

interface cpe_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[sv/cpe_ram.sv]
`timescale 1ns / 1ps
module cpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/cpe_ctrl.sv]
`timescale 1ns / 1ps
module cpe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cpe_pkg::dp_stat_t stat,
	output cpe_pkg::dp_cmd_t cmd,
	output cpe_pkg::uop_t    uop
);
	import cpe_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_FETCH, ST_EXEC, ST_DWAIT, ST_DONE} state_t;

	state_t         state_q;
	logic [PC_W-1:0] pc_q;

	assign uop = prog(pc_q);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.take = in_valid;
			ST_CHECK: begin
				cmd.restart  = stat.mode;
				cmd.set_fail = !stat.mode && stat.fail_hit;
			end
			ST_FETCH: cmd.issue = 1'b1;
			ST_EXEC:  cmd.exec = 1'b1;
			ST_DONE:  cmd.load_out = stat.out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					pc_q <= '0;
					if (stat.mode || stat.fail_hit) state_q <= ST_DONE;
					else state_q <= ST_FETCH;
				end
				ST_FETCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (is_div(uop.op)) begin
						state_q <= ST_DWAIT;
					end else if (pc_q == PROG_LAST) begin
						state_q <= ST_DONE;
					end else begin
						pc_q <= pc_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_DWAIT: begin
					if (stat.div_done) begin
						if (pc_q == PROG_LAST) begin
							state_q <= ST_DONE;
						end else begin
							pc_q <= pc_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_DONE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[sv/cpe_dpath.sv]
`timescale 1ns / 1ps
module cpe_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpe_pkg::dp_cmd_t      cmd,
	input  cpe_pkg::uop_t         uop,
	output cpe_pkg::dp_stat_t     stat,
	input  logic                  in_mode,
	input  cpe_pkg::word_t        in_force,
	input  logic                  cfg_we,
	input  logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cpe_pkg::word_t        out_position,
	output cpe_pkg::word_t        out_velocity,
	output cpe_pkg::word_t        out_angle,
	output cpe_pkg::word_t        out_rate,
	output logic                  out_failed
);
	import cpe_pkg::*;

	localparam int NUM_W = 56;
	localparam int CNT_W = 6;

	function automatic logic [WORD-1:0] mag(word_t a);
		return a[WORD-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic word_t sneg(word_t a);
		return (a == VMIN) ? VMAX : -a;
	endfunction

	function automatic word_t sadd(word_t a, word_t b);
		logic signed [WORD:0] s;
		s = {a[WORD-1], a} + {b[WORD-1], b};
		if (s[WORD] != s[WORD-1]) return s[WORD] ? VMIN : VMAX;
		return s[WORD-1:0];
	endfunction

	function automatic word_t satm(logic neg, logic [NUM_W-1:0] q);
		if (q > NUM_W'(VMAX)) return neg ? VMIN : VMAX;
		return neg ? -word_t'(q[WORD-1:0]) : word_t'(q[WORD-1:0]);
	endfunction

	function automatic word_t fmul(word_t a, word_t b);
		logic [63:0] p;
		p = {32'd0, mag(a)} * {32'd0, mag(b)};
		p = p + 64'(ROUND_HALF);
		return satm(a[WORD-1] ^ b[WORD-1], NUM_W'(p[63:FRAC]));
	endfunction

	// config
	word_t g_q;
	logic [30:0] mc_q, mp_q, l_q, fa_q, dt_q;
	// state
	word_t pa_q, vel_q, ang_q, rate_q;
	logic failed_q;
	logic mode_q;
	word_t force_q;
	// op in flight
	uop_t op_s1;
	word_t spa_s1, spb_s1;
	logic [1:0] k_q;
	// divider
	logic [NUM_W-1:0] n_q, q_q;
	logic [WORD-1:0] r_q, y_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q, dneg_q, dzero_q, dapos_q, daneg_q;
	// constant divisor: reciprocal estimate, then one correction
	logic [WORD-1:0] kx_q, kr_q, ke_q;
	logic kest_q, kfix_q;
	logic [2*WORD-1:0] kprod;
	logic [WORD-1:0] krem;

	word_t ram_a, ram_b, a_val, b_val, alu_res, div_res, wr_data;
	logic cond, wr_en;

	function automatic word_t spec(opnd_t c, word_t pa, word_t vel, word_t ang, word_t rate,
			word_t g, logic [30:0] mc, logic [30:0] mp, logic [30:0] l, logic [30:0] dt,
			word_t f);
		word_t v;
		case (c)
			S_PA:    v = pa;
			S_VEL:   v = vel;
			S_ANG:   v = ang;
			S_RATE:  v = rate;
			S_G:     v = g;
			S_MC:    v = {1'b0, mc};
			S_MP:    v = {1'b0, mp};
			S_L:     v = {1'b0, l};
			S_DT:    v = {1'b0, dt};
			S_FORCE: v = f;
			S_ONE:   v = ONE_VAL;
			S_FT:    v = FT_VAL;
			S_H2:    v = H2_VAL;
			S_H:     v = H_VAL;
			S_SD0:   v = 32'sd110;
			S_SD1:   v = 32'sd72;
			S_SD2:   v = 32'sd42;
			S_SD3:   v = 32'sd20;
			S_SD4:   v = 32'sd6;
			S_CD0:   v = 32'sd90;
			S_CD1:   v = 32'sd56;
			S_CD2:   v = 32'sd30;
			S_CD3:   v = 32'sd12;
			S_CD4:   v = 32'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	// floor(2^32 / d) for each constant divisor
	function automatic logic [WORD-1:0] krecip(opnd_t c);
		logic [WORD-1:0] v;
		case (c)
			S_H:     v = WORD'((64'd1 << WORD) / H64);
			S_SD0:   v = WORD'((64'd1 << WORD) / 64'd110);
			S_SD1:   v = WORD'((64'd1 << WORD) / 64'd72);
			S_SD2:   v = WORD'((64'd1 << WORD) / 64'd42);
			S_SD3:   v = WORD'((64'd1 << WORD) / 64'd20);
			S_SD4:   v = WORD'((64'd1 << WORD) / 64'd6);
			S_CD0:   v = WORD'((64'd1 << WORD) / 64'd90);
			S_CD1:   v = WORD'((64'd1 << WORD) / 64'd56);
			S_CD2:   v = WORD'((64'd1 << WORD) / 64'd30);
			S_CD3:   v = WORD'((64'd1 << WORD) / 64'd12);
			S_CD4:   v = WORD'((64'd1 << WORD) / 64'd2);
			default: v = '0;
		endcase
		return v;
	endfunction

	cpe_ram #(.WIDTH(WORD), .DEPTH(16)) u_ram_a (
		.clk(clk), .we(wr_en && !op_s1.dst[5]), .waddr(op_s1.dst[3:0]), .wdata(wr_data),
		.raddr(uop.src_a[3:0]), .rdata(ram_a)
	);

	cpe_ram #(.WIDTH(WORD), .DEPTH(16)) u_ram_b (
		.clk(clk), .we(wr_en && !op_s1.dst[5]), .waddr(op_s1.dst[3:0]), .wdata(wr_data),
		.raddr(uop.src_b[3:0]), .rdata(ram_b)
	);

	assign a_val = op_s1.src_a[5] ? spa_s1 : ram_a;
	assign b_val = op_s1.src_b[5] ? spb_s1 : ram_b;

	always_comb begin
		case (op_s1.cond)
			C_K0:    cond = k_q[0];
			C_K1:    cond = k_q[1];
			C_K01:   cond = k_q[0] ^ k_q[1];
			C_TNEG:  cond = ang_q[WORD-1];
			default: cond = 1'b0;
		endcase
	end

	always_comb begin
		case (op_s1.op)
			OP_ADD:  alu_res = sadd(a_val, b_val);
			OP_SUB:  alu_res = sadd(a_val, sneg(b_val));
			OP_NEG:  alu_res = sneg(a_val);
			OP_MUL:  alu_res = fmul(a_val, b_val);
			OP_MULK: alu_res = a_val * b_val;
			OP_ABSH: alu_res = mag(a_val) + b_val;
			OP_SUBR: alu_res = a_val - b_val;
			OP_SEL:  alu_res = cond ? a_val : b_val;
			OP_CNEG: alu_res = cond ? sneg(a_val) : a_val;
			OP_MOV:  alu_res = a_val;
			default: alu_res = a_val;
		endcase
	end

	always_comb begin
		if (dzero_q) div_res = dapos_q ? VMAX : (daneg_q ? VMIN : '0);
		else div_res = satm(dneg_q, q_q);
	end

	assign wr_en = (cmd.exec && !is_div(op_s1.op)) || done_q;
	assign wr_data = done_q ? div_res : alu_res;

	assign stat.mode = mode_q;
	assign stat.fail_hit = mag(ang_q) > {1'b0, fa_q};
	assign stat.div_done = done_q;
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= 32'sd164416717;
			mc_q <= 31'd16777216;
			mp_q <= 31'd1677722;
			l_q <= 31'd8388608;
			fa_q <= 31'd3513772;
			dt_q <= 31'd335544;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAVITY:   g_q <= cfg_data;
				CFG_CART_MASS: mc_q <= cfg_data[30:0];
				CFG_POLE_MASS: mp_q <= cfg_data[30:0];
				CFG_POLE_LEN:  l_q <= cfg_data[30:0];
				CFG_FAIL_ANG:  fa_q <= cfg_data[30:0];
				CFG_TIME_STEP: dt_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0;
			vel_q <= '0;
			ang_q <= '0;
			rate_q <= '0;
			failed_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			if (cmd.take) mode_q <= in_mode;
			if (cmd.restart) begin
				pa_q <= '0;
				vel_q <= '0;
				ang_q <= '0;
				rate_q <= '0;
				failed_q <= 1'b0;
			end else if (cmd.set_fail) begin
				failed_q <= 1'b1;
			end else if (wr_en && op_s1.dst[5]) begin
				case (op_s1.dst)
					S_PA:   pa_q <= wr_data;
					S_VEL:  vel_q <= wr_data;
					S_ANG:  ang_q <= wr_data;
					S_RATE: rate_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) force_q <= in_force;
		if (cmd.issue) begin
			op_s1 <= uop;
			spa_s1 <= spec(uop.src_a, pa_q, vel_q, ang_q, rate_q, g_q, mc_q, mp_q, l_q, dt_q,
				force_q);
			spb_s1 <= spec(uop.src_b, pa_q, vel_q, ang_q, rate_q, g_q, mc_q, mp_q, l_q, dt_q,
				force_q);
		end
		// the quadrant comes from the low bits of the reduction quotient
		if (done_q && op_s1.op == OP_DIVU) k_q <= q_q[1:0];
	end

	// restoring divider, one quotient bit per cycle
	logic [WORD:0] rs;
	logic ge;
	assign rs = {r_q, n_q[NUM_W-1]};
	assign ge = rs >= {1'b0, y_q};

	// the estimate is low by at most one, so one compare fixes it
	assign kprod = (2*WORD)'(kx_q) * (2*WORD)'(kr_q);
	assign krem = kx_q - ke_q * y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			kest_q <= 1'b0;
			kfix_q <= 1'b0;
		end else begin
			done_q <= (busy_q && cnt_q == CNT_W'(1)) || kfix_q;
			kest_q <= cmd.exec && is_div(op_s1.op) && (op_s1.op != OP_DIV);
			kfix_q <= kest_q;
			if (cmd.exec && op_s1.op == OP_DIV) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && is_div(op_s1.op)) begin
			n_q <= {(op_s1.op == OP_DIVU) ? a_val : mag(a_val), {(NUM_W-WORD){1'b0}}};
			y_q <= mag(b_val);
			r_q <= '0;
			q_q <= '0;
			dzero_q <= (b_val == '0);
			kx_q <= (op_s1.op == OP_DIVU) ? a_val : mag(a_val);
			kr_q <= krecip(op_s1.src_b);
			if (op_s1.op == OP_DIVU) begin
				dneg_q <= 1'b0;
				dapos_q <= (a_val != '0);
				daneg_q <= 1'b0;
			end else begin
				dneg_q <= a_val[WORD-1] ^ b_val[WORD-1];
				dapos_q <= !a_val[WORD-1] && (a_val != '0);
				daneg_q <= a_val[WORD-1];
			end
		end else if (busy_q) begin
			r_q <= ge ? WORD'(rs - {1'b0, y_q}) : rs[WORD-1:0];
			q_q <= {q_q[NUM_W-2:0], ge};
			n_q <= {n_q[NUM_W-2:0], 1'b0};
		end else if (kest_q) begin
			ke_q <= kprod[2*WORD-1:WORD];
		end else if (kfix_q) begin
			q_q <= NUM_W'(ke_q) + NUM_W'(krem >= y_q);
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_position <= cmd.restart ? '0 : pa_q;
			out_velocity <= vel_q;
			out_angle <= ang_q;
			out_rate <= rate_q;
			out_failed <= failed_q;
		end
	end
endmodule

[sv/cart_pole_euler_step_unit.sv]
`timescale 1ns / 1ps
// Cart-pole dynamics, one semi-implicit Euler step per input item, all values signed
// Q8.24. A restart or a failed-angle item goes from the check state straight to the
// done state, which loads the result register. A physics step runs a 74-operation
// microprogram through one shared ALU, each operation in a fetch and an execute
// state; the 11 divisions by a constant (range reduction and Taylor terms, done by
// reciprocal multiplication and one correction) and the 4 fixed-point divisions in
// the bit-serial divider also wait for the divider. One item is in work at a time;
// the result register lets the next item be taken while the last result waits.
// Configuration writes are taken every cycle and should be made while idle.
module cart_pole_euler_step_unit (
	input  logic    clk,
	input  logic    arst_n,
	cpe_in_if.sink  in_ch,
	cpe_out_if.source out_ch,
	cpe_cfg_if.sink cfg_ch
);
	import cpe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	uop_t     uop;

	assign cfg_ch.ready = 1'b1;

	cpe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.stat(stat), .cmd(cmd), .uop(uop)
	);

	cpe_dpath u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .uop(uop), .stat(stat),
		.in_mode(in_ch.mode), .in_force(in_ch.force_req),
		.cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_position(out_ch.new_position), .out_velocity(out_ch.new_velocity),
		.out_angle(out_ch.new_angle), .out_rate(out_ch.new_rate),
		.out_failed(out_ch.has_failed)
	);
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
import cpe_pkg::*;

typedef struct {
	longint pos;
	longint vel;
	longint ang;
	longint rate;
	bit     failed;
} pole_state_t;

class cart_pole_tracker;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	longint gravity, cart_mass, pole_mass, pole_len, fail_ang, dt;
	longint pos, vel, ang, rate;
	bit failed;
	pole_state_t expected_states[$];
	int errors;

	function new();
		gravity = 164416717;
		cart_mass = 16777216;
		pole_mass = 1677722;
		pole_len = 8388608;
		fail_ang = 3513772;
		dt = 335544;
		pos = 0;
		vel = 0;
		ang = 0;
		rate = 0;
		failed = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		longint u;
		u = longint'(data[30:0]);
		case (idx)
			CFG_GRAVITY:   gravity = longint'($signed(data));
			CFG_CART_MASS: cart_mass = u;
			CFG_POLE_MASS: pole_mass = u;
			CFG_POLE_LEN:  pole_len = u;
			CFG_FAIL_ANG:  fail_ang = u;
			CFG_TIME_STEP: dt = u;
			default: ;
		endcase
	endfunction

	function longint clamp(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function longint sneg(longint a);
		return a == WMIN ? WMAX : -a;
	endfunction

	function longint sadd(longint a, longint b);
		return clamp(a + b);
	endfunction

	function longint ssub(longint a, longint b);
		return sadd(a, sneg(b));
	endfunction

	function longint signed_mag(bit neg, logic [63:0] m);
		if (neg) return m > 64'd2147483647 ? WMIN : -longint'(m);
		return m > 64'd2147483647 ? WMAX : longint'(m);
	endfunction

	// round half away from zero on the magnitude
	function longint fmul(longint a, longint b);
		logic [63:0] x, y, p;
		x = a < 0 ? -a : a;
		y = b < 0 ? -b : b;
		p = (x * y + (64'd1 << 23)) >> 24;
		return signed_mag((a < 0) != (b < 0), p);
	endfunction

	function longint fdiv(longint a, longint b);
		logic [63:0] x, y, q;
		if (b == 0) return a > 0 ? WMAX : (a < 0 ? WMIN : 0);
		x = a < 0 ? -a : a;
		y = b < 0 ? -b : b;
		q = (x << 24) / y;
		return signed_mag((a < 0) != (b < 0), q);
	endfunction

	function void sin_cos(longint th, output longint sn, output longint cs);
		longint sdiv[5], cdiv[5];
		logic [63:0] h, u, k, kh;
		longint r, r2, s, c, os, oc, one;
		sdiv = '{110, 72, 42, 20, 6};
		cdiv = '{90, 56, 30, 12, 2};
		one = 64'sd16777216;
		h = (64'h3243F6A8885A308D + (64'd1 << 36)) >> 37;
		u = th < 0 ? -th : th;
		k = (u + h / 2) / h;
		kh = k * h;
		r = u >= kh ? longint'(u - kh) : -longint'(kh - u);
		r2 = fmul(r, r);
		s = one;
		c = one;
		for (int i = 0; i < 5; i++) begin
			s = ssub(one, fmul(r2, s) / sdiv[i]);
			c = ssub(one, fmul(r2, c) / cdiv[i]);
		end
		s = fmul(r, s);
		case (k[1:0])
			2'd0: begin os = s; oc = c; end
			2'd1: begin os = c; oc = sneg(s); end
			2'd2: begin os = sneg(s); oc = sneg(c); end
			default: begin os = sneg(c); oc = s; end
		endcase
		sn = th < 0 ? sneg(os) : os;
		cs = oc;
	endfunction

	function void advance(longint f);
		longint s, c, total, pml, w2s, tmp, num, den, thdd, xdd, nxd, nw, ft;
		ft = ((64'sd4 << 24) + 1) / 3;
		sin_cos(ang, s, c);
		total = sadd(cart_mass, pole_mass);
		pml = fmul(pole_mass, pole_len);
		w2s = fmul(fmul(rate, rate), s);
		tmp = fdiv(ssub(sneg(f), fmul(pml, w2s)), total);
		num = sadd(fmul(gravity, s), fmul(c, tmp));
		den = fmul(pole_len, ssub(ft, fdiv(fmul(pole_mass, fmul(c, c)), total)));
		thdd = fdiv(num, den);
		xdd = fdiv(sadd(f, fmul(pml, ssub(w2s, fmul(thdd, c)))), total);
		nxd = sadd(vel, fmul(xdd, dt));
		nw = sadd(rate, fmul(thdd, dt));
		pos = sadd(pos, fmul(nxd, dt));
		ang = sadd(ang, fmul(nw, dt));
		vel = nxd;
		rate = nw;
	endfunction

	function void take_command(bit mode, logic signed [31:0] f);
		pole_state_t st;
		longint amag;
		amag = ang < 0 ? -ang : ang;
		if (mode) begin
			pos = 0;
			vel = 0;
			ang = 0;
			rate = 0;
			failed = 0;
		end else if (amag > fail_ang) begin
			failed = 1;
		end else begin
			advance(longint'(f));
		end
		st = '{pos, vel, ang, rate, failed};
		expected_states.push_back(st);
	endfunction

	function void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	function void check_state(logic signed [31:0] p, logic signed [31:0] v,
			logic signed [31:0] a, logic signed [31:0] r, logic fl);
		pole_state_t st;
		if (expected_states.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, got pos %0d vel %0d ang %0d rate %0d failed %0b",
				$time, p, v, a, r, fl);
			return;
		end
		st = expected_states.pop_front();
		check_field("new_position", st.pos, longint'(p));
		check_field("new_velocity", st.vel, longint'(v));
		check_field("new_angle", st.ang, longint'(a));
		check_field("new_rate", st.rate, longint'(r));
		check_field("has_failed", longint'(st.failed), longint'(fl));
	endfunction
endclass

module tb_top;
	localparam longint CYCLE_LIMIT = 10_000_000;
	localparam logic signed [31:0] FORCE_SPAN = 32'sd167772160;

	logic clk;
	logic arst_n;
	cpe_in_if in_ch();
	cpe_out_if out_ch();
	cpe_cfg_if cfg_ch();

	cart_pole_tracker tracker;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;
	longint cycles;

	cart_pole_euler_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		tracker = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = 1'b0;
		in_ch.force_req = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		send_idle_pct = 24;
		recv_idle_pct = 48;
		hold_req = 1'b0;
		hold_left = 0;
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= 3000;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			tracker.take_command(in_ch.mode, in_ch.force_req);
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_state(out_ch.new_position, out_ch.new_velocity,
				out_ch.new_angle, out_ch.new_rate, out_ch.has_failed);
	end

	task automatic send_item(bit mode, logic signed [31:0] f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.force_req <= f;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (tracker.expected_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_params(logic [31:0] g, logic [31:0] mc, logic [31:0] mp,
			logic [31:0] len, logic [31:0] fa, logic [31:0] step);
		write_reg(CFG_GRAVITY, g);
		write_reg(CFG_CART_MASS, mc);
		write_reg(CFG_POLE_MASS, mp);
		write_reg(CFG_POLE_LEN, len);
		write_reg(CFG_FAIL_ANG, fa);
		write_reg(CFG_TIME_STEP, step);
	endtask

	function automatic logic signed [31:0] pick_force();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) return $signed($urandom());
		return $signed($urandom_range(0, 2 * FORCE_SPAN)) - FORCE_SPAN;
	endfunction

	// episodes: restart, then a run of steps with random forces, some noise between
	task automatic run_episodes(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			send_item(1'b1, $signed($urandom()));
			sent++;
			len = $urandom_range(3, 40);
			for (int i = 0; i < len && sent < n_items; i++) begin
				send_item(($urandom_range(19) == 0), pick_force());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: restart, force extremes, drive to failure, steps after failure
		send_item(1'b1, 32'sd0);
		send_item(1'b0, 32'sd0);
		send_item(1'b0, VMAX);
		send_item(1'b0, VMIN);
		send_item(1'b0, 32'sd1);
		send_item(1'b0, -32'sd1);
		send_item(1'b1, 32'sd5);
		for (int i = 0; i < 12; i++) send_item(1'b0, FORCE_SPAN);
		send_item(1'b0, 32'sd0);
		send_item(1'b0, -FORCE_SPAN);
		send_item(1'b1, 32'sd0);
		send_item(1'b0, 32'sd7);
		hold_req <= 1'b1;
		run_episodes(40);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 24; recv_idle_pct = 48; end
				1: begin send_idle_pct = 48; recv_idle_pct = 24; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (ph)
				0: load_params(32'h7FFFFFFF, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF,
					32'h7FFFFFFF);
				1: load_params(32'h80000000, 32'h1, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0);
				2: load_params($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
				3: load_params(32'd164416717, 32'd16777216, 32'd1677722, 32'd8388608,
					32'h7FFFFFFF, 32'd335544);
				default: load_params(32'd164416717, 32'd16777216, 32'd1677722, 32'd8388608,
					32'd3513772, 32'd335544);
			endcase
			run_episodes(280);
			drain();
		end

		if (tracker.errors == 0 && tracker.expected_states.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
